/* design/assert_macros.svh */
// Assertion macros shared by the tilt filter RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CHK_IMPLY(lbl, clk, rst_n, a, c)
`define CHK_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* design/ictf_pkg.sv */
// Package for the complementary tilt filter: payload structs, register
// indexes and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package ictf_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pitch_out;
        logic signed [31:0] roll_out;
        logic               accel_applied;
    } out_item_t;

    localparam logic [3:0] REG_GYRO_GAIN      = 4'd0;
    localparam logic [3:0] REG_BLEND_WEIGHT   = 4'd1;
    localparam logic [3:0] REG_MAGNITUDE_LOW  = 4'd2;
    localparam logic [3:0] REG_MAGNITUDE_HIGH = 4'd3;

    localparam int MAX_STEPS = 24;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] r;
        begin
            unique case (idx)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/imu_complementary_tilt_filter.sv */
// Complementary pitch/roll filter: serial gyro integration, CORDIC atan2,
// serial blend. Depends on ictf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One sample at a time. A sample without accelerometer correction runs the
// bit-serial gyro multiply and then passes through the done state to the
// output register; with correction it adds CORDIC_STEPS (capped at 24)
// CORDIC iterations, both atan2 running side by side, and then the
// bit-serial blend multiply. The result waits in an output register while the
// next request is taken; the pitch and roll state updates on every sample.
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ictf_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ictf_pkg::out_item_t out_data
);

    localparam int NSTEP = (CORDIC_STEPS > ictf_pkg::MAX_STEPS) ?
                           ictf_pkg::MAX_STEPS : CORDIC_STEPS;
    localparam logic [4:0] LAST_CORD = 5'(NSTEP - 1);
    localparam logic [4:0] LAST_GYRO = 5'd15;
    localparam logic [4:0] LAST_BLND = 5'd16;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GYRO  = 5'b00010,
        S_CORD  = 5'b00100,
        S_BLEND = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] cnt_reg;

    logic [15:0] gain_reg;
    logic [16:0] weight_reg, mlow_reg, mhigh_reg;

    logic signed [31:0] pitch_reg, roll_reg;
    logic               applied_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;

    // gyro multiply
    logic [15:0]        gsh_reg;
    logic signed [32:0] gxs_reg, gys_reg, gpx_reg, gpy_reg;

    // CORDIC
    logic signed [26:0] xp_reg, yp_reg, xr_reg, yr_reg;
    logic signed [25:0] zp_reg, zr_reg;
    logic               zerop_reg, zeror_reg;

    // blend multiply
    logic [16:0]        wsh_reg, csh_reg;
    logic signed [51:0] angp_reg, angr_reg, accp_reg, accr_reg, sp_reg, sr_reg;

    logic               out_valid_reg;
    ictf_pkg::out_item_t out_reg;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        begin
            if (v > 52'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -52'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    logic accept, emit;
    logic [16:0] abs_x, abs_y, abs_z;
    logic [18:0] mag;
    logic        mag_ok;
    logic signed [26:0] x0p, y0p, x0r, y0r;
    logic signed [25:0] z0p, z0r;
    logic signed [25:0] tab;
    logic signed [26:0] xp_nx, yp_nx, xr_nx, yr_nx;
    logic signed [25:0] zp_nx, zr_nx;
    logic signed [51:0] pitch_g, roll_g;
    logic [16:0] w_eff;
    logic signed [51:0] termp, termr;
    logic signed [51:0] shp, shr;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign emit = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        abs_x = ax_reg[15] ? 17'(-{ax_reg[15], ax_reg}) : {1'b0, ax_reg};
        abs_y = ay_reg[15] ? 17'(-{ay_reg[15], ay_reg}) : {1'b0, ay_reg};
        abs_z = az_reg[15] ? 17'(-{az_reg[15], az_reg}) : {1'b0, az_reg};
        mag = 19'(abs_x) + 19'(abs_y) + 19'(abs_z);
        mag_ok = (mag > 19'(mlow_reg)) && (mag < 19'(mhigh_reg));
    end

    // quadrant fold: x = az*256, y = ay or ax * 256
    always_comb
    begin
        logic signed [26:0] xs, yps, yrs;
        xs  = {{3{az_reg[15]}}, az_reg, 8'd0};
        yps = {{3{ay_reg[15]}}, ay_reg, 8'd0};
        yrs = {{3{ax_reg[15]}}, ax_reg, 8'd0};
        x0p = xs; y0p = yps; z0p = '0;
        x0r = xs; y0r = yrs; z0r = '0;
        if (xs < 0)
        begin
            if (yps >= 0)
            begin
                x0p = yps; y0p = -xs; z0p = 26'sd5898240;
            end
            else
            begin
                x0p = -yps; y0p = xs; z0p = -26'sd5898240;
            end
            if (yrs >= 0)
            begin
                x0r = yrs; y0r = -xs; z0r = 26'sd5898240;
            end
            else
            begin
                x0r = -yrs; y0r = xs; z0r = -26'sd5898240;
            end
        end
    end

    always_comb
    begin
        tab = 26'(ictf_pkg::atan_q16(cnt_reg));
        if (yp_reg >= 0)
        begin
            xp_nx = xp_reg + (yp_reg >>> cnt_reg);
            yp_nx = yp_reg - (xp_reg >>> cnt_reg);
            zp_nx = zp_reg + tab;
        end
        else
        begin
            xp_nx = xp_reg - (yp_reg >>> cnt_reg);
            yp_nx = yp_reg + (xp_reg >>> cnt_reg);
            zp_nx = zp_reg - tab;
        end
        if (yr_reg >= 0)
        begin
            xr_nx = xr_reg + (yr_reg >>> cnt_reg);
            yr_nx = yr_reg - (xr_reg >>> cnt_reg);
            zr_nx = zr_reg + tab;
        end
        else
        begin
            xr_nx = xr_reg - (yr_reg >>> cnt_reg);
            yr_nx = yr_reg + (xr_reg >>> cnt_reg);
            zr_nx = zr_reg - tab;
        end
    end

    always_comb
    begin
        logic signed [32:0] fp, fr;
        fp = gpx_reg + (gsh_reg[0] ? gxs_reg : 33'sd0);
        fr = gpy_reg + (gsh_reg[0] ? gys_reg : 33'sd0);
        pitch_g = 52'(sat32(52'(pitch_reg) + 52'(fp)));
        roll_g  = 52'(sat32(52'(roll_reg) - 52'(fr)));
        w_eff = (weight_reg > 17'd65536) ? 17'd65536 : weight_reg;
        termp = (wsh_reg[0] ? angp_reg : 52'sd0) + (csh_reg[0] ? accp_reg : 52'sd0);
        termr = (wsh_reg[0] ? angr_reg : 52'sd0) + (csh_reg[0] ? accr_reg : 52'sd0);
        shp = (sp_reg + termp) >>> 16;
        shr = (sr_reg + termr) >>> 16;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_GYRO;
            S_GYRO:  if (cnt_reg == LAST_GYRO) state_next = applied_reg ? S_CORD : S_DONE;
            S_CORD:  if (cnt_reg == LAST_CORD) state_next = S_BLEND;
            S_BLEND: if (cnt_reg == LAST_BLND) state_next = S_DONE;
            S_DONE:  if (emit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            gain_reg      <= 16'd10;
            weight_reg    <= 17'd64225;
            mlow_reg      <= 17'd8192;
            mhigh_reg     <= 17'd32768;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else if (state_reg != S_IDLE && state_reg != S_DONE)
                cnt_reg <= cnt_reg + 5'd1;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ictf_pkg::REG_GYRO_GAIN:      gain_reg  <= cfg_data[15:0];
                    ictf_pkg::REG_BLEND_WEIGHT:   weight_reg <= cfg_data;
                    ictf_pkg::REG_MAGNITUDE_LOW:  mlow_reg  <= cfg_data;
                    ictf_pkg::REG_MAGNITUDE_HIGH: mhigh_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_GYRO && cnt_reg == LAST_GYRO)
            begin
                pitch_reg <= pitch_g[31:0];
                roll_reg  <= roll_g[31:0];
            end
            if (state_reg == S_BLEND && cnt_reg == LAST_BLND)
            begin
                pitch_reg <= sat32(shp);
                roll_reg  <= sat32(shr);
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg  <= in_data.accel_x;
            ay_reg  <= in_data.accel_y;
            az_reg  <= in_data.accel_z;
            gsh_reg <= gain_reg;
            gxs_reg <= 33'(in_data.gyro_x);
            gys_reg <= 33'(in_data.gyro_y);
            gpx_reg <= '0;
            gpy_reg <= '0;
        end
        if (state_reg == S_GYRO)
        begin
            gpx_reg <= gpx_reg + (gsh_reg[0] ? gxs_reg : 33'sd0);
            gpy_reg <= gpy_reg + (gsh_reg[0] ? gys_reg : 33'sd0);
            gxs_reg <= gxs_reg <<< 1;
            gys_reg <= gys_reg <<< 1;
            gsh_reg <= gsh_reg >> 1;
            if (cnt_reg == 5'd0)
                applied_reg <= mag_ok;
            if (cnt_reg == LAST_GYRO)
            begin
                xp_reg <= x0p; yp_reg <= y0p; zp_reg <= z0p;
                xr_reg <= x0r; yr_reg <= y0r; zr_reg <= z0r;
                zerop_reg <= (az_reg == 16'sd0) && (ay_reg == 16'sd0);
                zeror_reg <= (az_reg == 16'sd0) && (ax_reg == 16'sd0);
                angp_reg <= pitch_g;
                angr_reg <= roll_g;
                wsh_reg  <= w_eff;
                csh_reg  <= 17'(18'd65536 - 18'(w_eff));
                sp_reg   <= 52'sd32768;
                sr_reg   <= 52'sd32768;
            end
        end
        if (state_reg == S_CORD)
        begin
            xp_reg <= xp_nx; yp_reg <= yp_nx; zp_reg <= zp_nx;
            xr_reg <= xr_nx; yr_reg <= yr_nx; zr_reg <= zr_nx;
            if (cnt_reg == LAST_CORD)
            begin
                accp_reg <= zerop_reg ? 52'sd0 : 52'(zp_nx);
                accr_reg <= zeror_reg ? 52'sd0 : 52'(zr_nx);
            end
        end
        if (state_reg == S_BLEND)
        begin
            sp_reg   <= sp_reg + termp;
            sr_reg   <= sr_reg + termr;
            angp_reg <= angp_reg <<< 1;
            angr_reg <= angr_reg <<< 1;
            accp_reg <= accp_reg <<< 1;
            accr_reg <= accr_reg <<< 1;
            wsh_reg  <= wsh_reg >> 1;
            csh_reg  <= csh_reg >> 1;
        end
        if (emit)
        begin
            out_reg.pitch_out     <= pitch_reg;
            out_reg.roll_out      <= roll_reg;
            out_reg.accel_applied <= applied_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CHK_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == S_GYRO)
    `CHK_NEXT(a_result_from_done, clk, rst_n, !out_valid_reg && !emit, !out_valid_reg)
    `CHK_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, (cnt_reg <= LAST_BLND) || (cnt_reg <= LAST_CORD))
    `CHK_IMPLY(a_cord_only_applied, clk, rst_n, state_reg == S_CORD, applied_reg)

endmodule

/* tb/tb_top.sv */
// Testbench for imu_complementary_tilt_filter: directed and random samples, predicted
// attitude compared with each whole result. Depends on ictf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int STEPS = 16;
    localparam int MAX_CYCLES = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [3:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    ictf_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_stall;
    ictf_pkg::out_item_t out_data;

    // predictor state and register copies
    int          gain_q;
    int          blend_q;
    int          mag_lo_q;
    int          mag_hi_q;
    logic signed [31:0] pitch_q;
    logic signed [31:0] roll_q;

    ictf_pkg::out_item_t attitude_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          timed_out = 1'b0;
    int          stall_mode;

    imu_complementary_tilt_filter #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v < 0)
            return ~((~v) >>> s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[24];
        tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    function automatic longint tilt_atan2(int yin, int xin);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        int n;
        x = longint'(xin) * 256;
        y = longint'(yin) * 256;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 90 * 65536;
            end
            else
            begin
                x = -y;
                y = t;
                z = -90 * 65536;
            end
        end
        n = (STEPS > 24) ? 24 : STEPS;
        for (int i = 0; i < n; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_entry(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_entry(i);
            end
        end
        return z;
    endfunction

    function automatic logic signed [31:0] mix(logic signed [31:0] ang, longint acc, longint w);
        longint s;
        s = w * longint'(ang) + (65536 - w) * acc + 32768;
        return clamp32(floor_shift(s, 16));
    endfunction

    function automatic ictf_pkg::out_item_t predict_attitude(ictf_pkg::in_item_t s);
        ictf_pkg::out_item_t r;
        longint mag;
        longint w;
        int ax;
        int ay;
        int az;
        ax = s.accel_x;
        ay = s.accel_y;
        az = s.accel_z;
        pitch_q = clamp32(longint'(pitch_q) + longint'(s.gyro_x) * gain_q);
        roll_q = clamp32(longint'(roll_q) - longint'(s.gyro_y) * gain_q);
        mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
        r.accel_applied = 1'b0;
        if (mag > mag_lo_q && mag < mag_hi_q)
        begin
            w = (blend_q > 65536) ? 65536 : blend_q;
            pitch_q = mix(pitch_q, tilt_atan2(ay, az), w);
            roll_q = mix(roll_q, tilt_atan2(ax, az), w);
            r.accel_applied = 1'b1;
        end
        r.pitch_out = pitch_q;
        r.roll_out = roll_q;
        return r;
    endfunction

    task automatic write_reg(logic [3:0] idx, int val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[16:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ictf_pkg::REG_GYRO_GAIN:      gain_q = val & 32'hffff;
            ictf_pkg::REG_BLEND_WEIGHT:   blend_q = val & 32'h1ffff;
            ictf_pkg::REG_MAGNITUDE_LOW:  mag_lo_q = val & 32'h1ffff;
            ictf_pkg::REG_MAGNITUDE_HIGH: mag_hi_q = val & 32'h1ffff;
            default: ;
        endcase
    endtask

    // wait out the block before a register write
    task automatic drain();
        int guard;
        guard = 0;
        while (attitude_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    // send one request; valid stays up between back-to-back samples
    task automatic send_sample(ictf_pkg::in_item_t s, bit hold);
        in_valid <= 1'b1;
        in_data <= s;
        do
            @(posedge clk);
        while (in_stall);
        attitude_q.push_back(predict_attitude(s));
        if (!hold)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic ictf_pkg::in_item_t sample_of(int ax, int ay, int az, int gx, int gy);
        ictf_pkg::in_item_t s;
        s.accel_x = ax[15:0];
        s.accel_y = ay[15:0];
        s.accel_z = az[15:0];
        s.gyro_x = gx[15:0];
        s.gyro_y = gy[15:0];
        return s;
    endfunction

    function automatic logic [15:0] rand_axis(int span);
        int m;
        m = $urandom_range(0, span);
        return 16'($urandom_range(0, 1) ? -m : m);
    endfunction

    // mostly in-band accelerometer so the correction path runs
    function automatic ictf_pkg::in_item_t rand_sample();
        ictf_pkg::in_item_t s;
        case ($urandom_range(0, 9))
            0, 1: s = ictf_pkg::in_item_t'(80'({$urandom, $urandom, $urandom}));
            default:
            begin
                s.accel_x = rand_axis(9000);
                s.accel_y = rand_axis(9000);
                s.accel_z = rand_axis(12000);
                s.gyro_x = 16'($urandom);
                s.gyro_y = 16'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic run_burst(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_sample(rand_sample(), burst > 1 && left > 1);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(0, 40)) @(posedge clk);
        end
    endtask

    task automatic test_directed();
        send_sample(sample_of(0, 0, 0, 0, 0), 0);
        send_sample(sample_of(4000, 3000, 10000, 100, -100), 0);
        send_sample(sample_of(32767, 32767, 32767, 32767, 32767), 1);
        send_sample(sample_of(-32768, -32768, -32768, -32768, -32768), 0);
        // negative z with zero y: near +180
        send_sample(sample_of(0, 0, -12000, 0, 0), 0);
        send_sample(sample_of(-5000, 0, -12000, 7, 7), 0);
        send_sample(sample_of(5000, -6000, -8000, -7, 3), 0);
        send_sample(sample_of(0, 12000, 0, 1, 1), 0);
        send_sample(sample_of(-9000, -9000, 0, 0, 0), 0);
        // at and just inside the thresholds: correction only strictly between them
        send_sample(sample_of(8192, 0, 0, 0, 0), 0);
        send_sample(sample_of(0, 0, 32768 - 1, 0, 0), 0);
        send_sample(sample_of(16384, 16384, 0, 0, 0), 0);
        send_sample(sample_of(16383, 16383, 1, 0, 0), 1);
        send_sample(sample_of(-1, 1, 9000, -1, 1), 0);
    endtask

    task automatic test_saturation();
        drain();
        write_reg(ictf_pkg::REG_GYRO_GAIN, 65535);
        write_reg(ictf_pkg::REG_MAGNITUDE_LOW, 98304);
        for (int i = 0; i < 8; i++)
            send_sample(sample_of(0, 0, 0, 32767, -32768), 1);
        for (int i = 0; i < 8; i++)
            send_sample(sample_of(0, 0, 0, -32768, 32767), i < 7);
    endtask

    task automatic test_blend_extremes();
        drain();
        write_reg(ictf_pkg::REG_GYRO_GAIN, 0);
        write_reg(ictf_pkg::REG_MAGNITUDE_LOW, 0);
        write_reg(ictf_pkg::REG_MAGNITUDE_HIGH, 98304);
        write_reg(ictf_pkg::REG_BLEND_WEIGHT, 0);
        run_burst(60);
        drain();
        // weight above one acts as one
        write_reg(ictf_pkg::REG_BLEND_WEIGHT, 131071);
        write_reg(ictf_pkg::REG_GYRO_GAIN, 1234);
        run_burst(60);
        drain();
        write_reg(ictf_pkg::REG_BLEND_WEIGHT, 65536);
        // index beyond the list is dropped
        write_reg(4'd9, 12345);
        write_reg(4'd15, 131071);
        run_burst(60);
    endtask

    task automatic test_inverted_thresholds();
        drain();
        write_reg(ictf_pkg::REG_MAGNITUDE_LOW, 40000);
        write_reg(ictf_pkg::REG_MAGNITUDE_HIGH, 20000);
        run_burst(80);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_reg(ictf_pkg::REG_GYRO_GAIN, $urandom_range(0, 65535));
            write_reg(ictf_pkg::REG_BLEND_WEIGHT, $urandom_range(50000, 131071));
            write_reg(ictf_pkg::REG_MAGNITUDE_LOW, $urandom_range(0, 8000));
            write_reg(ictf_pkg::REG_MAGNITUDE_HIGH, $urandom_range(20000, 131071));
            run_burst(270);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (attitude_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", out_data);
            end
            else
            begin
                ictf_pkg::out_item_t e;
                e = attitude_q.pop_front();
                if (e !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: pitch exp %0d got %0d, roll exp %0d got %0d, ",
                                  "applied exp %0b got %0b"},
                                 e.pitch_out, out_data.pitch_out, e.roll_out,
                                 out_data.roll_out, e.accel_applied, out_data.accel_applied);
                end
            end
        end
    end

    // receiver stall pattern, changing between modes
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= (cycles % 7) < 5;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        gain_q = 10;
        blend_q = 64225;
        mag_lo_q = 8192;
        mag_hi_q = 32768;
        pitch_q = '0;
        roll_q = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_blend_extremes();
        test_inverted_thresholds();
        test_random();
        guard = 0;
        while (attitude_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0 && attitude_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
